[hdl/assert_macros.svh]
// assertion macros used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked check, switched off while reset is held
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(name, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

[hdl/ubxfp_pkg.sv]
// types, register codes and constants of the ubx frame parser
`timescale 1ns / 1ps
`default_nettype none

package ubxfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LENLO   = 4'd4,
        PH_LENHI   = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CKA     = 4'd7,
        PH_CKB     = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        CFG_MAX_PAYLOAD  = 2'd0,
        CFG_MATCH_CLASS  = 2'd1,
        CFG_MATCH_ID     = 2'd2,
        CFG_MATCH_LENGTH = 2'd3
    } t_cfg_idx;

    localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd92;
    localparam logic [7:0]  MATCH_CLASS_RST  = 8'd1;
    localparam logic [7:0]  MATCH_ID_RST     = 8'd7;
    localparam logic [15:0] MATCH_LENGTH_RST = 16'd92;

    typedef struct packed {
        logic [15:0] max_payload;
        logic [7:0]  match_class;
        logic [7:0]  match_id;
        logic [15:0] match_length;
    } t_cfg;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_data;
        logic [15:0] payload_index;
        logic        frame_good;
        logic        frame_match;
        logic        checksum_bad;
        logic        length_reject;
        logic [31:0] bad_checksum_count;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] frame_length;
    } t_result;

endpackage

`default_nettype wire

[hdl/ubxfp_cfg.sv]
// configuration registers of the ubx frame parser
`timescale 1ns / 1ps
`default_nettype none

module ubxfp_cfg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_data,
    output      logic              o_cfg_ready,
    output      ubxfp_pkg::t_cfg   o_cfg
);
    import ubxfp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_PAYLOAD:  n_cfg.max_payload  = i_cfg_data;
                CFG_MATCH_CLASS:  n_cfg.match_class  = i_cfg_data[7:0];
                CFG_MATCH_ID:     n_cfg.match_id     = i_cfg_data[7:0];
                CFG_MATCH_LENGTH: n_cfg.match_length = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_payload  <= MAX_PAYLOAD_RST;
            r_cfg.match_class  <= MATCH_CLASS_RST;
            r_cfg.match_id     <= MATCH_ID_RST;
            r_cfg.match_length <= MATCH_LENGTH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

[hdl/ubxfp_parse.sv]
// frame state, fletcher checksum and per-byte result of the ubx frame parser
`timescale 1ns / 1ps
`default_nettype none

module ubxfp_parse (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [7:0]         i_rx_byte,
    input  wire ubxfp_pkg::t_cfg    i_cfg,
    output      ubxfp_pkg::t_result o_result
);
    import ubxfp_pkg::*;

    t_phase      r_phase,   n_phase;
    logic [7:0]  r_class,   n_class;
    logic [7:0]  r_id,      n_id;
    logic [15:0] r_len,     n_len;
    logic [15:0] r_pos,     n_pos;
    logic [7:0]  r_sum_a,   n_sum_a;
    logic [7:0]  r_sum_b,   n_sum_b;
    logic [7:0]  r_rx_ck_a, n_rx_ck_a;
    logic [31:0] r_errors,  n_errors;

    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [16:0] pos_next;
    t_result     res;

    // one fletcher step on the incoming byte
    assign add_a    = r_sum_a + i_rx_byte;
    assign add_b    = r_sum_b + add_a;
    assign pos_next = {1'b0, r_pos} + 17'd1;

    always_comb begin
        n_phase   = r_phase;
        n_class   = r_class;
        n_id      = r_id;
        n_len     = r_len;
        n_pos     = r_pos;
        n_sum_a   = r_sum_a;
        n_sum_b   = r_sum_b;
        n_rx_ck_a = r_rx_ck_a;
        n_errors  = r_errors;
        res       = '0;

        case (r_phase)
            PH_SYNC2: begin
                if (i_rx_byte == SYNC_SECOND) begin
                    n_phase = PH_CLASS;
                end else if (i_rx_byte == SYNC_FIRST) begin
                    n_phase = PH_SYNC2;
                end else begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_CLASS: begin
                n_class = i_rx_byte;
                n_sum_a = i_rx_byte;
                n_sum_b = i_rx_byte;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_id    = i_rx_byte;
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_phase = PH_LENLO;
            end
            PH_LENLO: begin
                n_len   = {8'd0, i_rx_byte};
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_phase = PH_LENHI;
            end
            PH_LENHI: begin
                n_len   = {i_rx_byte, r_len[7:0]};
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_pos   = '0;
                if (n_len > i_cfg.max_payload) begin
                    res.length_reject = 1'b1;
                    n_phase = PH_SYNC1;
                end else if (n_len == 16'd0) begin
                    n_phase = PH_CKA;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                res.payload_valid = 1'b1;
                res.payload_data  = i_rx_byte;
                res.payload_index = r_pos;
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_pos   = pos_next[15:0];
                if (pos_next >= {1'b0, r_len}) begin
                    n_phase = PH_CKA;
                end
            end
            PH_CKA: begin
                n_rx_ck_a = i_rx_byte;
                n_phase   = PH_CKB;
            end
            PH_CKB: begin
                n_phase = PH_SYNC1;
                if (r_rx_ck_a != r_sum_a || i_rx_byte != r_sum_b) begin
                    res.checksum_bad = 1'b1;
                    n_errors = r_errors + 32'd1;
                end else begin
                    res.frame_good  = 1'b1;
                    res.frame_match = (r_class == i_cfg.match_class) &&
                                      (r_id == i_cfg.match_id) &&
                                      (r_len == i_cfg.match_length);
                end
            end
            default: begin
                // first sync byte hunt, also taken by unused phase codes
                n_phase = (i_rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase

        res.bad_checksum_count = n_errors;
        res.frame_class        = n_class;
        res.frame_id           = n_id;
        res.frame_length       = n_len;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SYNC1;
            r_class   <= '0;
            r_id      <= '0;
            r_len     <= '0;
            r_pos     <= '0;
            r_sum_a   <= '0;
            r_sum_b   <= '0;
            r_rx_ck_a <= '0;
            r_errors  <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_class   <= n_class;
            r_id      <= n_id;
            r_len     <= n_len;
            r_pos     <= n_pos;
            r_sum_a   <= n_sum_a;
            r_sum_b   <= n_sum_b;
            r_rx_ck_a <= n_rx_ck_a;
            r_errors  <= n_errors;
        end
    end

endmodule

`default_nettype wire

[hdl/ubxfp_out_buf.sv]
// result register with skid entry of the ubx frame parser
`timescale 1ns / 1ps
`default_nettype none

module ubxfp_out_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire ubxfp_pkg::t_result i_result,
    output      logic               o_in_stall,
    output      logic               o_accept,
    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      ubxfp_pkg::t_result o_result
);
    import ubxfp_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    // the skid entry soaks up the beat taken in the cycle the stall rises
    assign o_in_stall  = r_skid_valid;
    assign o_accept    = i_in_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= o_accept;
            end
        end else if (o_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (o_accept) begin
            r_skid <= i_result;
        end
    end

endmodule

`default_nettype wire

[hdl/ubx_frame_parser_top.sv]
// ubx frame parser: sync hunt, header and payload framing, fletcher check
//
// input channel: one received byte per beat on i_rx_byte, qualified by
// i_in_valid and held off by o_in_stall.
// output channel: one result per input byte, qualified by o_out_valid and
// held off by i_out_stall. payload bytes come out with their index; the
// byte that closes a frame raises frame_good (and frame_match when class,
// id and length equal the configured ones) or checksum_bad.
// configuration: i_cfg_valid / o_cfg_ready write i_cfg_data to register
// i_cfg_index (0 max payload, 1 class, 2 id, 3 length); always ready.
// the result of a byte is registered in the result register or the skid entry.
// throughput: one byte per cycle while o_in_stall is low; the phase and checksum
// update is combinational between the input beat and the result register.
// stall: a result register plus one skid entry; o_in_stall rises once both
// hold results, so one byte more is taken after i_out_stall rises.
// reset: synchronous, active low; parser hunts for the first sync byte,
// the error count is zero and the registers take their defaults.
`timescale 1ns / 1ps
`default_nettype none

module ubx_frame_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic        o_payload_valid,
    output      logic [7:0]  o_payload_data,
    output      logic [15:0] o_payload_index,
    output      logic        o_frame_good,
    output      logic        o_frame_match,
    output      logic        o_checksum_bad,
    output      logic        o_length_reject,
    output      logic [31:0] o_bad_checksum_count,
    output      logic [7:0]  o_frame_class,
    output      logic [7:0]  o_frame_id,
    output      logic [15:0] o_frame_length,
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import ubxfp_pkg::*;

    t_cfg    cfg;
    t_result step_res;
    t_result out_res;
    logic    accept;

    ubxfp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    ubxfp_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (cfg),
        .o_result  (step_res)
    );

    ubxfp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_result    (step_res),
        .o_in_stall  (o_in_stall),
        .o_accept    (accept),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_res)
    );

    assign o_payload_valid      = out_res.payload_valid;
    assign o_payload_data       = out_res.payload_data;
    assign o_payload_index      = out_res.payload_index;
    assign o_frame_good         = out_res.frame_good;
    assign o_frame_match        = out_res.frame_match;
    assign o_checksum_bad       = out_res.checksum_bad;
    assign o_length_reject      = out_res.length_reject;
    assign o_bad_checksum_count = out_res.bad_checksum_count;
    assign o_frame_class        = out_res.frame_class;
    assign o_frame_id           = out_res.frame_id;
    assign o_frame_length       = out_res.frame_length;

`include "assert_macros.svh"

    // skid entry only fills behind a held result
    `ASSERT_CLK(a_skid_behind_out, i_clk, i_rst_n, o_in_stall |-> o_out_valid, "skid without result")

    // a payload beat never closes or rejects a frame
    `ASSERT_CLK(a_payload_not_end, i_clk, i_rst_n, (o_out_valid && o_payload_valid) |-> !(o_frame_good || o_checksum_bad || o_length_reject), "payload beat flagged as frame end")

    // a match is only reported on a good frame
    `ASSERT_CLK(a_match_needs_good, i_clk, i_rst_n, (o_out_valid && o_frame_match) |-> (o_frame_good && !o_checksum_bad), "match without good frame")

    // good and bad checksum never together
    `ASSERT_CLK(a_good_xor_bad, i_clk, i_rst_n, o_out_valid |-> !(o_frame_good && o_checksum_bad), "good and bad checksum together")

endmodule

`default_nettype wire

[tb/sv/tb_ubx_frame_parser_top.sv]
// testbench of the ubx frame parser: framed and broken byte streams checked against a parser model
`timescale 1ns / 1ps

import ubxfp_pkg::*;

typedef enum int {CK_OK, CK_BAD_A, CK_BAD_B} t_ck_fault;

class ubx_frame_tracker;
    logic [15:0] max_payload;
    logic [7:0]  match_class;
    logic [7:0]  match_id;
    logic [15:0] match_length;

    t_phase      phase;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] length;
    logic [15:0] pos;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  rx_ck_a;
    logic [31:0] err_total;

    t_result     due_results[$];
    int unsigned mismatches;

    function new();
        max_payload  = MAX_PAYLOAD_RST;
        match_class  = MATCH_CLASS_RST;
        match_id     = MATCH_ID_RST;
        match_length = MATCH_LENGTH_RST;
        phase        = PH_SYNC1;
        cls          = '0;
        id           = '0;
        length       = '0;
        pos          = '0;
        sum_a        = '0;
        sum_b        = '0;
        rx_ck_a      = '0;
        err_total    = '0;
        mismatches   = 0;
    endfunction

    function void set_reg(t_cfg_idx idx, logic [15:0] val);
        case (idx)
            CFG_MAX_PAYLOAD:  max_payload = val;
            CFG_MATCH_CLASS:  match_class = val[7:0];
            CFG_MATCH_ID:     match_id = val[7:0];
            CFG_MATCH_LENGTH: match_length = val;
            default: ;
        endcase
    endfunction

    function void fold(logic [7:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endfunction

    // one accepted byte always yields exactly one result
    function void take_byte(logic [7:0] b);
        t_result     r;
        logic [15:0] idx;
        r = '0;
        case (phase)
            PH_SYNC2: begin
                if (b == SYNC_SECOND) phase = PH_CLASS;
                else if (b == SYNC_FIRST) phase = PH_SYNC2;
                else phase = PH_SYNC1;
            end
            PH_CLASS: begin
                cls = b;
                sum_a = b;
                sum_b = b;
                phase = PH_ID;
            end
            PH_ID: begin
                id = b;
                fold(b);
                phase = PH_LENLO;
            end
            PH_LENLO: begin
                length = {8'd0, b};
                fold(b);
                phase = PH_LENHI;
            end
            PH_LENHI: begin
                length = {b, length[7:0]};
                fold(b);
                pos = '0;
                if (length > max_payload) begin
                    r.length_reject = 1'b1;
                    phase = PH_SYNC1;
                end else if (length == 16'd0) begin
                    phase = PH_CKA;
                end else begin
                    phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                idx = pos;
                r.payload_valid = 1'b1;
                r.payload_data = b;
                r.payload_index = idx;
                fold(b);
                pos = pos + 16'd1;
                if ({16'd0, idx} + 32'd1 >= {16'd0, length}) phase = PH_CKA;
            end
            PH_CKA: begin
                rx_ck_a = b;
                phase = PH_CKB;
            end
            PH_CKB: begin
                phase = PH_SYNC1;
                if (rx_ck_a != sum_a || b != sum_b) begin
                    r.checksum_bad = 1'b1;
                    err_total = err_total + 32'd1;
                end else begin
                    r.frame_good = 1'b1;
                    if (cls == match_class && id == match_id && length == match_length)
                        r.frame_match = 1'b1;
                end
            end
            default: begin
                if (b == SYNC_FIRST) phase = PH_SYNC2;
                else phase = PH_SYNC1;
            end
        endcase
        r.bad_checksum_count = err_total;
        r.frame_class = cls;
        r.frame_id = id;
        r.frame_length = length;
        due_results.push_back(r);
    endfunction

    function string show(t_result r);
        return $sformatf({"pv=%0d data=%02h idx=%0d good=%0d match=%0d bad=%0d rej=%0d",
                          " errs=%0d cls=%02h id=%02h len=%0d"},
                         r.payload_valid, r.payload_data, r.payload_index, r.frame_good,
                         r.frame_match, r.checksum_bad, r.length_reject,
                         r.bad_checksum_count, r.frame_class, r.frame_id, r.frame_length);
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: %s", show(got));
        end else begin
            want = due_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t", $realtime);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        end
    endfunction

    function int pending();
        return due_results.size();
    endfunction
endclass

module tb_ubx_frame_parser_top;
    localparam int PHASE_BEATS    = 370;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_payload_valid;
    logic [7:0]  o_payload_data;
    logic [15:0] o_payload_index;
    logic        o_frame_good;
    logic        o_frame_match;
    logic        o_checksum_bad;
    logic        o_length_reject;
    logic [31:0] o_bad_checksum_count;
    logic [7:0]  o_frame_class;
    logic [7:0]  o_frame_id;
    logic [15:0] o_frame_length;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    ubx_frame_tracker tracker;
    t_result          seen;
    bit               calm = 1'b0;
    bit               hold_req = 1'b0;
    int               hold_left = 0;
    int               burst_left = 0;
    int               run_left = 0;
    int               idle_cycles = 0;
    int unsigned      framed_beats = 0;

    ubx_frame_parser_top u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_rx_byte            (i_rx_byte),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_payload_valid      (o_payload_valid),
        .o_payload_data       (o_payload_data),
        .o_payload_index      (o_payload_index),
        .o_frame_good         (o_frame_good),
        .o_frame_match        (o_frame_match),
        .o_checksum_bad       (o_checksum_bad),
        .o_length_reject      (o_length_reject),
        .o_bad_checksum_count (o_bad_checksum_count),
        .o_frame_class        (o_frame_class),
        .o_frame_id           (o_frame_id),
        .o_frame_length       (o_frame_length),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    assign seen = {o_payload_valid, o_payload_data, o_payload_index, o_frame_good,
                   o_frame_match, o_checksum_bad, o_length_reject, o_bad_checksum_count,
                   o_frame_class, o_frame_id, o_frame_length};

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_result(seen);
    end

    // receiver: random stall bursts, one long hold on request, none once calm
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (calm || !i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (burst_left == 0 && run_left == 0) begin
                burst_left = $urandom_range(1, 18);
                if ($urandom_range(0, 7) == 0) run_left = $urandom_range(60, 200);
                else run_left = $urandom_range(0, 24);
            end
            if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else begin
                run_left--;
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.take_byte(b);
    endtask

    task automatic frame_byte(input logic [7:0] b);
        send_byte(b);
        framed_beats++;
    endtask

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input t_ck_fault fault,
                              input int dup, input int cut);
        logic [7:0] hdr[4];
        logic [7:0] ca;
        logic [7:0] cb;
        logic [7:0] pb;
        logic [7:0] flip;
        int         n;
        hdr = '{cls, id, len[7:0], len[15:8]};
        ca = '0;
        cb = '0;
        flip = 8'($urandom_range(1, 255));
        frame_byte(SYNC_FIRST);
        repeat (dup) frame_byte(SYNC_FIRST);
        frame_byte(SYNC_SECOND);
        for (int i = 0; i < 4; i++) begin
            frame_byte(hdr[i]);
            ca = ca + hdr[i];
            cb = cb + ca;
        end
        if (len <= tracker.max_payload) begin
            n = int'(len);
            if (cut >= 0 && cut < n) n = cut;
            for (int i = 0; i < n; i++) begin
                pb = 8'($urandom);
                frame_byte(pb);
                ca = ca + pb;
                cb = cb + ca;
            end
            // a cut frame leaves the parser inside the payload
            if (n == int'(len)) begin
                if (fault == CK_BAD_A) ca = ca ^ flip;
                if (fault == CK_BAD_B) cb = cb ^ flip;
                frame_byte(ca);
                frame_byte(cb);
            end
        end
    endtask

    function automatic logic [15:0] pick_len();
        int unsigned lim;
        lim = (tracker.max_payload < 16'd24) ? 32'(tracker.max_payload) : 32'd24;
        if ($urandom_range(0, 15) == 0)
            lim = (tracker.max_payload < 16'd300) ? 32'(tracker.max_payload) : 32'd300;
        return 16'($urandom_range(0, lim));
    endfunction

    task automatic random_frame();
        int          kind;
        int          dup;
        int          cut;
        int          n;
        logic [15:0] len;
        logic [7:0]  junk;
        t_ck_fault   fault;
        kind = $urandom_range(0, 99);
        dup = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
        len = pick_len();
        fault = CK_BAD_A;
        if ($urandom_range(0, 1) == 1) fault = CK_BAD_B;
        if (kind < 45) begin
            send_frame(8'($urandom), 8'($urandom), len, CK_OK, dup, -1);
        end else if (kind < 55) begin
            if (tracker.match_length <= tracker.max_payload &&
                tracker.match_length <= 16'd100)
                len = tracker.match_length;
            send_frame(tracker.match_class, tracker.match_id, len, CK_OK, dup, -1);
        end else if (kind < 65) begin
            if ($urandom_range(0, 1) == 1)
                send_frame(tracker.match_class, tracker.match_id, len, fault, dup, -1);
            else
                send_frame(8'($urandom), 8'($urandom), len, fault, dup, -1);
        end else if (kind < 75) begin
            if (tracker.max_payload != 16'hFFFF) begin
                case ($urandom_range(0, 2))
                    0: len = tracker.max_payload + 16'd1;
                    1: len = 16'hFFFF;
                    default: len = 16'($urandom_range(32'(tracker.max_payload) + 1, 65535));
                endcase
            end
            send_frame(8'($urandom), 8'($urandom), len, CK_OK, dup, -1);
        end else if (kind < 85) begin
            cut = (len > 16'd0) ? $urandom_range(0, 32'(len) - 1) : -1;
            send_frame(8'($urandom), 8'($urandom), len, CK_OK, dup, cut);
        end else if (kind < 90) begin
            // lone first sync byte followed by something else
            do junk = 8'($urandom); while (junk == SYNC_FIRST || junk == SYNC_SECOND);
            send_byte(SYNC_FIRST);
            send_byte(junk);
        end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 9))
                    0, 1: junk = SYNC_FIRST;
                    2: junk = SYNC_SECOND;
                    default: junk = 8'($urandom);
                endcase
                send_byte(junk);
            end
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.set_reg(idx, val);
    endtask

    // class and id carry junk in the upper byte, which the block must drop
    task automatic write_cfg(input logic [15:0] mx, input logic [7:0] mc,
                             input logic [7:0] mi, input logic [15:0] ml);
        drain();
        put_reg(CFG_MAX_PAYLOAD, mx);
        put_reg(CFG_MATCH_CLASS, {8'($urandom), mc});
        put_reg(CFG_MATCH_ID, {8'($urandom), mi});
        put_reg(CFG_MATCH_LENGTH, ml);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned goal;
        logic [15:0] mx;
        logic [15:0] ml;
        logic [7:0]  mc;
        logic [7:0]  mi;
        tracker = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: repeated sync, zero length, broken sync, rejected length, bad checksum
        send_frame(8'h01, 8'h07, 16'd0, CK_OK, 1, -1);
        send_byte(SYNC_FIRST);
        send_byte(8'h41);
        send_frame(8'h00, 8'hFF, 16'hFFFF, CK_OK, 0, -1);
        send_frame(8'hFF, 8'h00, 16'd1, CK_BAD_B, 0, -1);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin mx = 16'd92; mc = 8'd1; mi = 8'd7; ml = 16'd92; end
                1: begin mx = 16'd0; mc = 8'd0; mi = 8'd0; ml = 16'd0; end
                2: begin mx = 16'hFFFF; mc = 8'hFF; mi = 8'hFF; ml = 16'hFFFF; end
                3: begin
                    mx = 16'd16;
                    mc = 8'($urandom);
                    mi = 8'($urandom);
                    ml = 16'($urandom_range(0, 16));
                end
                default: begin
                    mx = 16'($urandom_range(20, 200));
                    mc = 8'($urandom);
                    mi = 8'($urandom);
                    ml = 16'($urandom_range(0, 60));
                end
            endcase
            write_cfg(mx, mc, mi, ml);
            if (p == 0) begin
                // long receiver hold while bytes keep coming, so the input backs up
                hold_req = 1'b1;
                send_frame(8'($urandom), 8'($urandom), 16'd40, CK_OK, 0, -1);
                drain();
            end
            goal = framed_beats + PHASE_BEATS;
            while (framed_beats < goal) begin
                if (p == 4 && framed_beats + PHASE_BEATS / 2 >= goal) calm = 1'b1;
                random_frame();
            end
        end

        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

[ubx_frame_parser_top.f]
+incdir+hdl
hdl/ubxfp_pkg.sv
hdl/ubxfp_cfg.sv
hdl/ubxfp_parse.sv
hdl/ubxfp_out_buf.sv
hdl/ubx_frame_parser_top.sv
tb/sv/tb_ubx_frame_parser_top.sv
